### rtl/cidx_pkg.sv
package cidx_pkg;

  // access kind
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // port decode
  typedef enum logic [1:0] {
    PORT_INDEX = 2'd0,
    PORT_DATA  = 2'd1,
    PORT_A20   = 2'd2,
    PORT_RESET = 2'd3
  } port_t;

  localparam int unsigned LAST_WRITABLE_DEFAULT = 36;

  // register indexes
  localparam logic [7:0] IDX_RO_BIT       = 8'd5;
  localparam logic [7:0] SHADOW_FIRST_IDX = 8'd13;
  localparam logic [7:0] RO_BIT_MASK      = 8'h10;

  localparam int unsigned SHADOW_REGS       = 6;
  localparam int unsigned REGIONS_PER_REG   = 4;
  localparam int unsigned REGIONS           = SHADOW_REGS * REGIONS_PER_REG;
  localparam int unsigned BIOS_FIRST_REGION = 16;

  localparam logic [7:0] BYTE_ALL_ONES = 8'hff;

  typedef logic [SHADOW_REGS-1:0][7:0] shadow_bank_t;

  typedef struct packed {
    logic [REGIONS-1:0] rd;
    logic [REGIONS-1:0] wr;
    logic               bios_rd;
    logic               bios_wr;
  } shadow_map_t;

  // power-on contents of the register file
  function automatic logic [7:0] reset_value(input logic [7:0] idx);
    logic [7:0] val;
    case (idx)
      8'd0:    val = 8'h90;
      8'd1:    val = 8'hff;
      8'd2:    val = 8'h8a;
      8'd3:    val = 8'h88;
      8'd6:    val = 8'h1b;
      8'd8:    val = 8'h38;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

### rtl/cidx_shadow_dec.sv
module cidx_shadow_dec (
  input  cidx_pkg::shadow_bank_t regs,
  output cidx_pkg::shadow_map_t  map
);

  // two bits per region: upper is internal read, lower is internal write
  always_comb begin
    map = '0;
    for (int j = 0; j < int'(cidx_pkg::SHADOW_REGS); j++) begin
      for (int s = 0; s < int'(cidx_pkg::REGIONS_PER_REG); s++) begin
        map.rd[j*cidx_pkg::REGIONS_PER_REG + s] = regs[j][2*s+1];
        map.wr[j*cidx_pkg::REGIONS_PER_REG + s] = regs[j][2*s];
      end
    end
    map.bios_rd = |map.rd[cidx_pkg::REGIONS-1:cidx_pkg::BIOS_FIRST_REGION];
    map.bios_wr = |map.wr[cidx_pkg::REGIONS-1:cidx_pkg::BIOS_FIRST_REGION];
  end

endmodule

### rtl/chipset_index_data_shadow_regs.sv
// an accepted word passes the input register, then the result register, which strobes it
// throughput: one word per cycle, busy is never raised in normal running
// the receiver cannot stall, each result is shown for exactly one cycle
// reset (rst_n low, synchronous): index clears, register file reads power-on
// values again, shadow regions all external; busy is set by reset and cleared once rst_n is high
module chipset_index_data_shadow_regs #(
  parameter int unsigned LAST_WRITABLE_INDEX = cidx_pkg::LAST_WRITABLE_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [1:0]  in_port_offset,
  input  logic [7:0]  in_write_data,
  input  logic        in_a20_alternate,
  output logic        out_valid,
  output logic [7:0]  out_read_data,
  output logic [23:0] out_shadow_read_internal,
  output logic [23:0] out_shadow_write_internal,
  output logic        out_bios_shadow_read,
  output logic        out_bios_shadow_write,
  output logic        out_a20_enable_request,
  output logic        out_a20_disable_request,
  output logic        out_cpu_reset_request
);

  // register file depth and address width
  localparam int unsigned DEPTH = LAST_WRITABLE_INDEX + 1;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // input register stage
  logic       busy_r;
  logic       v1_r;
  logic       cmd1_r;
  logic [1:0] port1_r;
  logic [7:0] wd1_r;
  logic       alt1_r;

  // architectural state
  logic [7:0]             index_r;
  logic [7:0]             mem [DEPTH];
  logic [DEPTH-1:0]       valid_r;
  cidx_pkg::shadow_bank_t shadow_r;

  // result register
  logic       out_valid_r;
  logic [7:0] mem_rd_r;
  logic       use_mem_r;
  logic [7:0] alt_rd_r;
  logic       a20_en_r;
  logic       a20_dis_r;
  logic       cpu_rst_r;

  // decode of the word in the input register
  logic          accept;
  logic          is_write;
  logic          is_read;
  logic          in_range;
  logic          data_wr_en;
  logic [AW-1:0] addr;
  logic [7:0]    wr_byte;
  logic          use_mem_nxt;
  logic [7:0]    alt_rd_nxt;
  cidx_pkg::port_t      port1;
  cidx_pkg::shadow_map_t smap;

  assign accept   = start & ~busy_r;
  assign busy     = busy_r;
  assign port1    = cidx_pkg::port_t'(port1_r);
  assign is_write = v1_r & (cmd1_r == cidx_pkg::CMD_WRITE);
  assign is_read  = v1_r & (cmd1_r == cidx_pkg::CMD_READ);
  assign addr     = index_r[AW-1:0];

  // index 0 and everything above the last writable index are read-only
  assign in_range   = ({24'd0, index_r} <= 32'(LAST_WRITABLE_INDEX));
  assign data_wr_en = is_write & (port1 == cidx_pkg::PORT_DATA) &
                      (index_r != 8'd0) & in_range;

  // bit 4 of index 5 is never writable, so it keeps its power-on zero
  assign wr_byte = (index_r == cidx_pkg::IDX_RO_BIT) ?
                   (wd1_r & ~cidx_pkg::RO_BIT_MASK) : wd1_r;

  // a data read takes the file only where the entry was written since reset
  assign use_mem_nxt = is_read & (port1 == cidx_pkg::PORT_DATA) & in_range &
                       valid_r[addr];

  always_comb begin
    alt_rd_nxt = 8'h00;
    if (cmd1_r == cidx_pkg::CMD_READ) begin
      case (port1)
        cidx_pkg::PORT_INDEX: alt_rd_nxt = index_r;
        cidx_pkg::PORT_DATA:  alt_rd_nxt = cidx_pkg::reset_value(index_r);
        default:              alt_rd_nxt = cidx_pkg::BYTE_ALL_ONES;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      a20_en_r    <= 1'b0;
      a20_dis_r   <= 1'b0;
      cpu_rst_r   <= 1'b0;
      index_r     <= 8'h00;
      valid_r     <= '0;
      shadow_r    <= '0;
    end else begin
      busy_r      <= 1'b0;
      v1_r        <= accept;
      out_valid_r <= v1_r;
      a20_en_r    <= is_read & (port1 == cidx_pkg::PORT_A20) & ~alt1_r;
      a20_dis_r   <= is_write & (port1 == cidx_pkg::PORT_A20) & alt1_r;
      cpu_rst_r   <= is_read & (port1 == cidx_pkg::PORT_RESET);
      if (is_write && (port1 == cidx_pkg::PORT_INDEX)) begin
        index_r <= wd1_r;
      end
      if (data_wr_en) begin
        valid_r[addr] <= 1'b1;
      end
      // shadow copies kept in flops so the region map is always visible
      for (int j = 0; j < int'(cidx_pkg::SHADOW_REGS); j++) begin
        if (data_wr_en && (index_r == cidx_pkg::SHADOW_FIRST_IDX + 8'(j))) begin
          shadow_r[j] <= wd1_r;
        end
      end
    end
  end

  // input word capture, no reset needed on payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd1_r  <= in_cmd;
      port1_r <= in_port_offset;
      wd1_r   <= in_write_data;
      alt1_r  <= in_a20_alternate;
    end
  end

  // register file: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (data_wr_en) begin
      mem[addr] <= wr_byte;
    end
    mem_rd_r  <= mem[addr];
    use_mem_r <= use_mem_nxt;
    alt_rd_r  <= alt_rd_nxt;
  end

  cidx_shadow_dec u_shadow_dec (
    .regs (shadow_r),
    .map  (smap)
  );

  // the shadow flops are updated at the same edge as the strobe, so the map
  // shown with the result is the one that stands after the access
  assign out_valid                 = out_valid_r;
  assign out_read_data             = use_mem_r ? mem_rd_r : alt_rd_r;
  assign out_shadow_read_internal  = smap.rd;
  assign out_shadow_write_internal = smap.wr;
  assign out_bios_shadow_read      = smap.bios_rd;
  assign out_bios_shadow_write     = smap.bios_wr;
  assign out_a20_enable_request    = a20_en_r;
  assign out_a20_disable_request   = a20_dis_r;
  assign out_cpu_reset_request     = cpu_rst_r;

endmodule

### rtl/cidx_checker.sv
module cidx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_cmd,
  input logic        out_valid,
  input logic [7:0]  out_read_data,
  input logic [23:0] out_shadow_read_internal,
  input logic        out_bios_shadow_read,
  input logic        out_a20_enable_request,
  input logic        out_a20_disable_request,
  input logic        out_cpu_reset_request
);

  // every accepted word gives its result once through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted word produced no result");

  // no result without a word accepted through the input register before it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result strobe without an accepted word");

  // request pulses only travel with a result
  a_pulse_framed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_a20_enable_request || out_a20_disable_request || out_cpu_reset_request)
      |-> out_valid)
    else $error("request pulse outside a result");

  // a write word returns zero data
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_cmd, 2)) |-> (out_read_data == 8'h00))
    else $error("write word returned non-zero data");

  // bios read flag follows the top eight regions
  a_bios_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bios_shadow_read == (out_shadow_read_internal[23:16] != 8'h00)))
    else $error("bios shadow read flag disagrees with region map");

endmodule

bind chipset_index_data_shadow_regs cidx_checker u_cidx_checker (
  .clk                      (clk),
  .rst_n                    (rst_n),
  .start                    (start),
  .busy                     (busy),
  .in_cmd                   (in_cmd),
  .out_valid                (out_valid),
  .out_read_data            (out_read_data),
  .out_shadow_read_internal (out_shadow_read_internal),
  .out_bios_shadow_read     (out_bios_shadow_read),
  .out_a20_enable_request   (out_a20_enable_request),
  .out_a20_disable_request  (out_a20_disable_request),
  .out_cpu_reset_request    (out_cpu_reset_request)
);

### tb/sv/testbench.sv
module testbench;
  import cidx_pkg::*;

  // register indexes used by the directed table
  localparam logic [7:0] IDX_FIRST_RW    = 8'd1;
  localparam logic [7:0] IDX_LAST_RW     = 8'(LAST_WRITABLE_DEFAULT);
  localparam logic [7:0] IDX_PAST_RW     = IDX_LAST_RW + 8'd1;
  localparam logic [7:0] SHADOW_LAST_IDX = SHADOW_FIRST_IDX + 8'(SHADOW_REGS - 1);

  localparam int RANDOM_WORDS   = 650;
  localparam int PRESSURE_POINT = 320;
  localparam int DRAIN_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int REPORT_LIMIT   = 10;

  // one bus access as the block reports it
  typedef struct packed {
    logic [7:0]         read_data;
    logic [REGIONS-1:0] shadow_rd;
    logic [REGIONS-1:0] shadow_wr;
    logic               bios_rd;
    logic               bios_wr;
    logic               a20_en;
    logic               a20_dis;
    logic               cpu_rst;
  } access_result_t;

  // directed row: expected read data typed in only where it is obvious
  typedef struct packed {
    logic       cmd;
    port_t      port;
    logic [7:0] wd;
    logic       alt;
    logic       typed;
    logic [7:0] typed_rd;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_cmd;
  logic [1:0]  in_port_offset;
  logic [7:0]  in_write_data;
  logic        in_a20_alternate;
  logic        out_valid;
  logic [7:0]  out_read_data;
  logic [23:0] out_shadow_read_internal;
  logic [23:0] out_shadow_write_internal;
  logic        out_bios_shadow_read;
  logic        out_bios_shadow_write;
  logic        out_a20_enable_request;
  logic        out_a20_disable_request;
  logic        out_cpu_reset_request;

  // our own copy of the chipset state
  logic [7:0] index_copy;
  logic [7:0] regs_copy [256];

  access_result_t pending_results [$];

  int failures;
  int reports;
  int words_sent;
  int results_checked;
  int a20_en_seen, a20_dis_seen, cpu_rst_seen, bios_rd_seen, bios_wr_seen;
  bit no_gap_stretch;

  chipset_index_data_shadow_regs DUT (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .start                     (start),
    .busy                      (busy),
    .in_cmd                    (in_cmd),
    .in_port_offset            (in_port_offset),
    .in_write_data             (in_write_data),
    .in_a20_alternate          (in_a20_alternate),
    .out_valid                 (out_valid),
    .out_read_data             (out_read_data),
    .out_shadow_read_internal  (out_shadow_read_internal),
    .out_shadow_write_internal (out_shadow_write_internal),
    .out_bios_shadow_read      (out_bios_shadow_read),
    .out_bios_shadow_write     (out_bios_shadow_write),
    .out_a20_enable_request    (out_a20_enable_request),
    .out_a20_disable_request   (out_a20_disable_request),
    .out_cpu_reset_request     (out_cpu_reset_request)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // power-on contents, as the chipset comes out of reset
  task automatic clear_state_copy();
    index_copy = 8'h00;
    for (int i = 0; i < 256; i++) begin
      regs_copy[i] = 8'h00;
    end
    regs_copy[0] = 8'h90;
    regs_copy[1] = 8'hff;
    regs_copy[2] = 8'h8a;
    regs_copy[3] = 8'h88;
    regs_copy[6] = 8'h1b;
    regs_copy[8] = 8'h38;
  endtask

  // applies one access to the state copy and works out what the block shows
  function automatic access_result_t apply_access(input logic cmd, input port_t port,
                                                  input logic [7:0] wd, input logic alt);
    access_result_t res;
    logic [7:0] shadow_byte;
    res = '0;
    if (cmd == CMD_WRITE) begin
      case (port)
        PORT_INDEX: index_copy = wd;
        PORT_DATA: begin
          // index 0 and anything past the last writable index are left alone
          if (index_copy >= IDX_FIRST_RW && index_copy <= IDX_LAST_RW) begin
            if (index_copy == IDX_RO_BIT)
              regs_copy[index_copy] = (regs_copy[index_copy] & RO_BIT_MASK) |
                                      (wd & ~RO_BIT_MASK);
            else
              regs_copy[index_copy] = wd;
          end
        end
        PORT_A20: res.a20_dis = alt;
        default: ;  // writes to the reset port do nothing
      endcase
    end else begin
      res.read_data = BYTE_ALL_ONES;
      case (port)
        PORT_INDEX: res.read_data = index_copy;
        PORT_DATA:  res.read_data = regs_copy[index_copy];
        PORT_A20:   res.a20_en = ~alt;
        default:    res.cpu_rst = 1'b1;
      endcase
    end
    // region map after the access: two bits per region, read on the odd bit
    for (int k = 0; k < REGIONS; k++) begin
      shadow_byte = regs_copy[SHADOW_FIRST_IDX + 8'(k / REGIONS_PER_REG)];
      res.shadow_rd[k] = shadow_byte[2 * (k % REGIONS_PER_REG) + 1];
      res.shadow_wr[k] = shadow_byte[2 * (k % REGIONS_PER_REG)];
    end
    res.bios_rd = |res.shadow_rd[REGIONS-1:BIOS_FIRST_REGION];
    res.bios_wr = |res.shadow_wr[REGIONS-1:BIOS_FIRST_REGION];
    return res;
  endfunction

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gap_stretch || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offers one word, waits for it to be taken, then records the expectation
  task automatic drive_word(input logic cmd, input port_t port, input logic [7:0] wd,
                            input logic alt, input logic typed, input logic [7:0] typed_rd);
    access_result_t exp;
    int gap;
    start            <= 1'b1;
    in_cmd           <= cmd;
    in_port_offset   <= port;
    in_write_data    <= wd;
    in_a20_alternate <= alt;
    do @(posedge clk); while (busy !== 1'b0);
    exp = apply_access(cmd, port, wd, alt);
    if (typed) exp.read_data = typed_rd;
    pending_results.push_back(exp);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] exp,
                               input logic [31:0] act);
    failures++;
    if (reports < REPORT_LIMIT) begin
      reports++;
      $display("  result %0d: %s expected %h, got %h", results_checked, field, exp, act);
    end
  endtask

  // result side: every strobe must match the oldest outstanding word
  always @(posedge clk) begin
    access_result_t exp;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected strobe", 32'h0, 32'(out_valid));
      end else begin
        exp = pending_results.pop_front();
        if (out_read_data !== exp.read_data)
          note_mismatch("read_data", 32'(exp.read_data), 32'(out_read_data));
        if (out_shadow_read_internal !== exp.shadow_rd)
          note_mismatch("shadow_read_internal", 32'(exp.shadow_rd),
                        32'(out_shadow_read_internal));
        if (out_shadow_write_internal !== exp.shadow_wr)
          note_mismatch("shadow_write_internal", 32'(exp.shadow_wr),
                        32'(out_shadow_write_internal));
        if (out_bios_shadow_read !== exp.bios_rd)
          note_mismatch("bios_shadow_read", 32'(exp.bios_rd), 32'(out_bios_shadow_read));
        if (out_bios_shadow_write !== exp.bios_wr)
          note_mismatch("bios_shadow_write", 32'(exp.bios_wr), 32'(out_bios_shadow_write));
        if (out_a20_enable_request !== exp.a20_en)
          note_mismatch("a20_enable_request", 32'(exp.a20_en),
                        32'(out_a20_enable_request));
        if (out_a20_disable_request !== exp.a20_dis)
          note_mismatch("a20_disable_request", 32'(exp.a20_dis),
                        32'(out_a20_disable_request));
        if (out_cpu_reset_request !== exp.cpu_rst)
          note_mismatch("cpu_reset_request", 32'(exp.cpu_rst), 32'(out_cpu_reset_request));
        a20_en_seen  += exp.a20_en;
        a20_dis_seen += exp.a20_dis;
        cpu_rst_seen += exp.cpu_rst;
        bios_rd_seen += exp.bios_rd;
        bios_wr_seen += exp.bios_wr;
        results_checked++;
      end
    end
  end

  // directed words: power-on values, index limits, the read-only bit,
  // shadow extremes, every port in both directions
  stim_row_t directed_rows [0:26] = '{
    '{CMD_READ,  PORT_INDEX, 8'h00,           1'b0, 1'b1, 8'h00},
    '{CMD_READ,  PORT_DATA,  8'hff,           1'b1, 1'b1, 8'h90},
    '{CMD_WRITE, PORT_DATA,  8'h00,           1'b0, 1'b1, 8'h00},  // index 0 is locked
    '{CMD_READ,  PORT_DATA,  8'h00,           1'b0, 1'b1, 8'h90},
    '{CMD_WRITE, PORT_INDEX, IDX_FIRST_RW,    1'b0, 1'b0, 8'h00},
    '{CMD_READ,  PORT_DATA,  8'h00,           1'b0, 1'b1, 8'hff},
    '{CMD_WRITE, PORT_DATA,  8'h00,           1'b0, 1'b0, 8'h00},
    '{CMD_READ,  PORT_DATA,  8'h00,           1'b0, 1'b1, 8'h00},
    '{CMD_WRITE, PORT_INDEX, IDX_RO_BIT,      1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, PORT_DATA,  8'hff,           1'b0, 1'b0, 8'h00},
    '{CMD_READ,  PORT_DATA,  8'h00,           1'b0, 1'b1, 8'hef},  // bit 4 held
    '{CMD_WRITE, PORT_INDEX, SHADOW_FIRST_IDX, 1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, PORT_DATA,  8'haa,           1'b0, 1'b0, 8'h00},  // low regions read
    '{CMD_WRITE, PORT_INDEX, SHADOW_LAST_IDX, 1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, PORT_DATA,  8'h55,           1'b0, 1'b0, 8'h00},  // bios area write
    '{CMD_WRITE, PORT_INDEX, IDX_LAST_RW,     1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, PORT_DATA,  8'h5a,           1'b0, 1'b0, 8'h00},
    '{CMD_READ,  PORT_DATA,  8'h00,           1'b0, 1'b1, 8'h5a},
    '{CMD_WRITE, PORT_INDEX, IDX_PAST_RW,     1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, PORT_DATA,  8'ha5,           1'b0, 1'b0, 8'h00},  // past the file
    '{CMD_READ,  PORT_DATA,  8'h00,           1'b0, 1'b1, 8'h00},
    '{CMD_READ,  PORT_A20,   8'h00,           1'b0, 1'b1, 8'hff},  // gate on
    '{CMD_READ,  PORT_A20,   8'h00,           1'b1, 1'b1, 8'hff},  // no effect
    '{CMD_WRITE, PORT_A20,   8'hff,           1'b1, 1'b1, 8'h00},  // gate off
    '{CMD_WRITE, PORT_A20,   8'hff,           1'b0, 1'b1, 8'h00},  // no effect
    '{CMD_READ,  PORT_RESET, 8'h00,           1'b0, 1'b1, 8'hff},
    '{CMD_WRITE, PORT_RESET, 8'h00,           1'b0, 1'b1, 8'h00}   // ignored
  };

  initial begin
    int n;
    int drain;
    bit paused;
    logic [7:0] idx;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_cmd           = CMD_READ;
    in_port_offset   = PORT_INDEX;
    in_write_data    = 8'h00;
    in_a20_alternate = 1'b0;
    failures         = 0;
    reports          = 0;
    words_sent       = 0;
    results_checked  = 0;
    a20_en_seen      = 0;
    a20_dis_seen     = 0;
    cpu_rst_seen     = 0;
    bios_rd_seen     = 0;
    bios_wr_seen     = 0;
    no_gap_stretch   = 1'b0;
    paused           = 1'b0;
    clear_state_copy();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(directed_rows); i++) begin
      drive_word(directed_rows[i].cmd, directed_rows[i].port, directed_rows[i].wd,
                 directed_rows[i].alt, directed_rows[i].typed, directed_rows[i].typed_rd);
    end

    // random part: mostly an index word followed by a few data accesses,
    // the rest unrelated accesses on any port
    while (words_sent < $size(directed_rows) + RANDOM_WORDS) begin
      no_gap_stretch = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 9) == 0)
          idx = 8'($urandom_range(0, 255));
        else
          idx = 8'($urandom_range(0, int'(IDX_PAST_RW) + 1));
        drive_word(CMD_WRITE, PORT_INDEX, idx, 1'($urandom_range(0, 1)), 1'b0, 8'h00);
        n = $urandom_range(1, 4);
        repeat (n) begin
          drive_word(1'($urandom_range(0, 1)), PORT_DATA, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'b0, 8'h00);
        end
      end else begin
        drive_word(1'($urandom_range(0, 1)), port_t'($urandom_range(0, 3)),
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 8'h00);
      end
      // hold off once until the block has drained completely
      if (!paused && words_sent >= PRESSURE_POINT) begin
        paused = 1'b1;
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
    end
    start <= 1'b0;

    // drain, bounded, then a few quiet cycles for stray strobes
    drain = 0;
    while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    failures += pending_results.size();

    $display("%0d words sent, %0d results checked, a20 on/off pulses %0d/%0d, cpu resets %0d",
             words_sent, results_checked, a20_en_seen, a20_dis_seen, cpu_rst_seen);
    $display("bios area shadowed for read in %0d results, for write in %0d",
             bios_rd_seen, bios_wr_seen);
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #(12 * 400000);
    $display("Mismatches found");
    $finish;
  end

endmodule
